// File: hw/rtl/ssm_pkg.sv
// Shared types and constants for the sorted stream merge block.
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = PTR_W + 1;
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        OP_PUSH      = 2'd0,
        OP_PUSH_LAST = 2'd1,
        OP_END       = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_ELEM  = 2'd0,
        ST_DROP  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic              kind;
        op_t               op;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              source;
        status_t           status;
        logic              merge_end;
        logic              run_last;
    } res_t;

endpackage

// File: hw/rtl/ssm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ssm_front.sv
// Input stage: registers a request and classifies it into a merge command.
`timescale 1ns / 1ps

module ssm_front
    import ssm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [DATA_W-1:0] value,
    input  logic              is_last,
    input  logic              list_empty,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    logic take;

    assign in_ready = !hold_valid_reg || cmd_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (hold_valid_reg && cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (take)
        begin
            hold_valid_next     = 1'b1;
            hold_cmd_next.kind  = kind;
            hold_cmd_next.value = value;
            if (list_empty)
            begin
                hold_cmd_next.op = OP_END;
            end
            else if (is_last)
            begin
                hold_cmd_next.op = OP_PUSH_LAST;
            end
            else
            begin
                hold_cmd_next.op = OP_PUSH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_cmd_reg;

endmodule

// File: hw/rtl/ssm_cmd_fifo.sv
// Two-entry command queue between the input stage and the merge engine.
`timescale 1ns / 1ps

module ssm_cmd_fifo
    import ssm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/ssm_back.sv
// Merge engine: per-list queues, head compare, pop sequencing and result register.
`timescale 1ns / 1ps

module ssm_back
    import ssm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic out_valid,
    input  logic out_ready,
    output res_t res
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_READ   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_a_reg;
    logic [CNT_W-1:0]  cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg;
    logic [CNT_W-1:0]  cnt_b_next;
    logic [PTR_W-1:0]  head_a_reg;
    logic [PTR_W-1:0]  head_a_next;
    logic [PTR_W-1:0]  head_b_reg;
    logic [PTR_W-1:0]  head_b_next;
    logic              ended_a_reg;
    logic              ended_a_next;
    logic              ended_b_reg;
    logic              ended_b_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [DATA_W-1:0] pend_value_reg;
    logic [DATA_W-1:0] pend_value_next;
    logic              pend_src_reg;
    logic              pend_src_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              res_reg;
    res_t              res_next;

    logic              out_free;
    logic              sel_ended;
    logic [CNT_W-1:0]  sel_cnt;
    logic [PTR_W-1:0]  sel_head;
    logic              drop;
    logic [SUM_W-1:0]  wsum;
    logic [PTR_W-1:0]  waddr;
    logic              we_a;
    logic              we_b;
    logic              re;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;
    logic              pick_any;
    logic              pick;
    logic              done;

    ssm_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (cmd.value),
        .re    (re),
        .raddr (head_a_reg),
        .rdata (rdata_a)
    );

    ssm_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (cmd.value),
        .re    (re),
        .raddr (head_b_reg),
        .rdata (rdata_b)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign sel_ended = cmd.kind ? ended_b_reg : ended_a_reg;
    assign sel_cnt   = cmd.kind ? cnt_b_reg : cnt_a_reg;
    assign sel_head  = cmd.kind ? head_b_reg : head_a_reg;
    assign drop      = sel_ended ||
                       ((cmd.op != OP_END) && (sel_cnt >= CNT_W'(QUEUE_DEPTH)));

    always_comb
    begin
        wsum = SUM_W'(sel_head) + SUM_W'(sel_cnt);
        if (wsum >= SUM_W'(QUEUE_DEPTH))
        begin
            wsum = wsum - SUM_W'(QUEUE_DEPTH);
        end
    end

    assign waddr = wsum[PTR_W-1:0];
    assign re    = (state_reg == S_READ);

    // Choose the next element to release, if any is decided.
    always_comb
    begin
        pick_any = 1'b0;
        pick     = 1'b0;
        if ((cnt_a_reg != '0) && (cnt_b_reg != '0))
        begin
            pick_any = 1'b1;
            pick     = !($signed(rdata_a) <= $signed(rdata_b));
        end
        else if ((cnt_a_reg != '0) && ended_b_reg &&
                 (ended_a_reg || (cnt_a_reg > CNT_W'(1))))
        begin
            pick_any = 1'b1;
            pick     = 1'b0;
        end
        else if ((cnt_b_reg != '0) && ended_a_reg &&
                 (ended_b_reg || (cnt_b_reg > CNT_W'(1))))
        begin
            pick_any = 1'b1;
            pick     = 1'b1;
        end
    end

    assign done = ended_a_reg && ended_b_reg && (cnt_a_reg == '0) && (cnt_b_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        head_a_next     = head_a_reg;
        head_b_next     = head_b_reg;
        ended_a_next    = ended_a_reg;
        ended_b_next    = ended_b_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_src_next   = pend_src_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        res_next        = res_reg;
        cmd_ready       = 1'b0;
        we_a            = 1'b0;
        we_b            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (drop)
                    begin
                        if (out_free)
                        begin
                            cmd_ready          = 1'b1;
                            out_valid_next     = 1'b1;
                            res_next.value     = '0;
                            res_next.source    = cmd.kind;
                            res_next.status    = ST_DROP;
                            res_next.merge_end = 1'b0;
                            res_next.run_last  = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_ready  = 1'b1;
                        state_next = S_READ;
                        if (cmd.kind)
                        begin
                            if (cmd.op != OP_END)
                            begin
                                we_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + CNT_W'(1);
                            end
                            if (cmd.op != OP_PUSH)
                            begin
                                ended_b_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (cmd.op != OP_END)
                            begin
                                we_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + CNT_W'(1);
                            end
                            if (cmd.op != OP_PUSH)
                            begin
                                ended_a_next = 1'b1;
                            end
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (pick_any)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next     = 1'b1;
                            res_next.value     = pend_value_reg;
                            res_next.source    = pend_src_reg;
                            res_next.status    = ST_ELEM;
                            res_next.merge_end = 1'b0;
                            res_next.run_last  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_src_next   = pick;
                        if (pick)
                        begin
                            pend_value_next = rdata_b;
                            cnt_b_next      = cnt_b_reg - CNT_W'(1);
                            head_b_next     = (head_b_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                              '0 : head_b_reg + PTR_W'(1);
                        end
                        else
                        begin
                            pend_value_next = rdata_a;
                            cnt_a_next      = cnt_a_reg - CNT_W'(1);
                            head_a_next     = (head_a_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                              '0 : head_a_reg + PTR_W'(1);
                        end
                        state_next = S_READ;
                    end
                end
                else if (pend_valid_reg || done)
                begin
                    if (out_free)
                    begin
                        out_valid_next     = 1'b1;
                        res_next.merge_end = done;
                        res_next.run_last  = 1'b1;
                        if (pend_valid_reg)
                        begin
                            res_next.value  = pend_value_reg;
                            res_next.source = pend_src_reg;
                            res_next.status = ST_ELEM;
                        end
                        else
                        begin
                            res_next.value  = '0;
                            res_next.source = 1'b0;
                            res_next.status = ST_EMPTY;
                        end
                        pend_valid_next = 1'b0;
                        if (done)
                        begin
                            ended_a_next = 1'b0;
                            ended_b_next = 1'b0;
                            head_a_next  = '0;
                            head_b_next  = '0;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            head_a_reg     <= '0;
            head_b_reg     <= '0;
            ended_a_reg    <= 1'b0;
            ended_b_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            head_a_reg     <= head_a_next;
            head_b_reg     <= head_b_next;
            ended_a_reg    <= ended_a_next;
            ended_b_reg    <= ended_b_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        pend_src_reg   <= pend_src_next;
        res_reg        <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/sorted_stream_merge.sv
// Top level of the two-list sorted stream merge.
//
// Input channel (in_valid/in_ready): one request per element of list A
// (kind 0) or list B (kind 1), with is_last on the final element or
// list_empty to end a list with no element. Output channel
// (out_valid/out_ready): merged elements in ascending order, drop reports
// and the empty-merge report, with merge_end and run_last flags.
// A request passes an input register and a two-entry command queue before
// the engine takes it. The engine writes a drop report into the result
// register as it takes the request; an empty-merge report follows a queue
// RAM read and a head compare. Each released element takes a queue RAM
// read, then a head compare and pop, and waits one decision in a holding
// register. The engine works on one request at a time. The newest element
// of a list not yet ended is held back while the other list holds no
// element, so that the last merged element can carry merge_end.
// Reset clears counts, pointers, end flags and all valid bits; queue RAM
// contents are not cleared. When the receiver stalls, the result register
// holds, the engine waits once it has another result to emit, and the
// command queue fills until in_ready drops.
`timescale 1ns / 1ps

module sorted_stream_merge
    import ssm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [DATA_W-1:0] value,
    input  logic              is_last,
    input  logic              list_empty,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_value,
    output logic              source,
    output logic [1:0]        status,
    output logic              merge_end,
    output logic              run_last
);

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic eng_valid;
    logic eng_ready;
    cmd_t eng_cmd;
    res_t res;

    ssm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .is_last    (is_last),
        .list_empty (list_empty),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    ssm_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (eng_valid),
        .pop_ready  (eng_ready),
        .pop_cmd    (eng_cmd)
    );

    ssm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (eng_valid),
        .cmd_ready (eng_ready),
        .cmd       (eng_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign out_value = res.value;
    assign source    = res.source;
    assign status    = res.status;
    assign merge_end = res.merge_end;
    assign run_last  = res.run_last;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the two-list sorted stream merge block.
`timescale 1ns / 1ps

module tb
    import ssm_pkg::*;
();

    localparam logic LIST_A       = 1'b0;
    localparam logic LIST_B       = 1'b1;
    localparam int   RANDOM_REQS  = 350;
    localparam int   DRAIN_CYCLES = 200;
    localparam int   LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] value;
        logic              is_last;
        logic              list_empty;
    } merge_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_value;
        logic              source;
        logic [1:0]        status;
        logic              merge_end;
        logic              run_last;
    } merge_res_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic              kind       = 1'b0;
    logic [DATA_W-1:0] value      = '0;
    logic              is_last    = 1'b0;
    logic              list_empty = 1'b0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [DATA_W-1:0] out_value;
    logic              source;
    logic [1:0]        status;
    logic              merge_end;
    logic              run_last;

    merge_req_t        pending_reqs[$];
    merge_res_t        merge_expected[$];
    logic [DATA_W-1:0] held_a[$];
    logic [DATA_W-1:0] held_b[$];
    bit                a_done = 1'b0;
    bit                b_done = 1'b0;
    int                sort_buf[$];
    merge_req_t        cur_req;
    int                in_gap    = 0;
    int                out_gap   = 0;
    bit                in_calm   = 1'b0;
    bit                out_calm  = 1'b0;
    int                errors    = 0;
    int                cycles    = 0;

    sorted_stream_merge u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .is_last    (is_last),
        .list_empty (list_empty),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_value  (out_value),
        .source     (source),
        .status     (status),
        .merge_end  (merge_end),
        .run_last   (run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("mismatch on %s: got %0h, expected %0h at cycle %0d",
                 what, got, want, cycles);
        errors++;
    endtask

    function automatic int pick_gap(inout bit calm);
        int r;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic void predict_merge(merge_req_t r);
        merge_res_t        pend;
        bit                have_pend;
        bit                done;
        logic              pick;
        logic [DATA_W-1:0] v;
        pend      = '0;
        have_pend = 1'b0;
        done      = 1'b0;
        pick      = LIST_A;
        if ((r.kind == LIST_A ? a_done : b_done) ||
            (!r.list_empty &&
             (r.kind == LIST_A ? held_a.size() : held_b.size()) >= QUEUE_DEPTH))
        begin
            pend.source   = r.kind;
            pend.status   = ST_DROP;
            pend.run_last = 1'b1;
            merge_expected.push_back(pend);
            return;
        end
        if (r.list_empty)
        begin
            if (r.kind == LIST_A)
                a_done = 1'b1;
            else
                b_done = 1'b1;
        end
        else if (r.kind == LIST_A)
        begin
            held_a.push_back(r.value);
            if (r.is_last)
                a_done = 1'b1;
        end
        else
        begin
            held_b.push_back(r.value);
            if (r.is_last)
                b_done = 1'b1;
        end
        while (!done)
        begin
            if (held_a.size() > 0 && held_b.size() > 0)
                pick = ($signed(held_a[0]) <= $signed(held_b[0])) ? LIST_A : LIST_B;
            else if (held_a.size() > 0 && b_done && (a_done || held_a.size() > 1))
                pick = LIST_A;
            else if (held_b.size() > 0 && a_done && (b_done || held_b.size() > 1))
                pick = LIST_B;
            else
                done = 1'b1;
            if (!done)
            begin
                if (pick == LIST_A)
                    v = held_a.pop_front();
                else
                    v = held_b.pop_front();
                if (have_pend)
                    merge_expected.push_back(pend);
                pend           = '0;
                pend.out_value = v;
                pend.source    = pick;
                pend.status    = ST_ELEM;
                have_pend      = 1'b1;
            end
        end
        if (a_done && b_done && held_a.size() == 0 && held_b.size() == 0)
        begin
            if (!have_pend)
            begin
                pend        = '0;
                pend.status = ST_EMPTY;
                have_pend   = 1'b1;
            end
            pend.merge_end = 1'b1;
            a_done         = 1'b0;
            b_done         = 1'b0;
        end
        if (have_pend)
        begin
            pend.run_last = 1'b1;
            merge_expected.push_back(pend);
        end
    endfunction

    task automatic add_req(logic k, logic [DATA_W-1:0] v, logic last, logic emp);
        merge_req_t r;
        r.kind       = k;
        r.value      = v;
        r.is_last    = last;
        r.list_empty = emp;
        pending_reqs.push_back(r);
    endtask

    task automatic add_noise();
        add_req(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0));
    endtask

    task automatic fill_sorted(int n, int mode);
        int s;
        sort_buf.delete();
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: s = int'($urandom);
                1: s = int'($urandom_range(0, 16)) - 8;
                2: s = ($urandom_range(0, 1) == 0) ?
                       int'(32'h80000000 + $urandom_range(0, 3)) :
                       int'(32'h7FFFFFFF - $urandom_range(0, 3));
                default: s = int'($urandom_range(0, 2000)) - 1000;
            endcase
            sort_buf.push_back(s);
        end
        sort_buf.sort();
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 80)
            return $urandom_range(1, 5);
        return $urandom_range(6, 16);
    endfunction

    task automatic build_list(logic k, int n, inout merge_req_t lst[$]);
        merge_req_t r;
        bit         by_marker;
        by_marker = ($urandom_range(0, 4) == 0);
        fill_sorted(n, $urandom_range(0, 3));
        for (int i = 0; i < n; i++)
        begin
            r.kind       = k;
            r.value      = sort_buf[i];
            r.is_last    = (i == n - 1) && !by_marker;
            r.list_empty = 1'b0;
            lst.push_back(r);
        end
        if (n == 0 || by_marker)
        begin
            r.kind       = k;
            r.value      = $urandom;
            r.is_last    = 1'($urandom_range(0, 1));
            r.list_empty = 1'b1;
            lst.push_back(r);
        end
    endtask

    task automatic build_merge(int la, int lb);
        merge_req_t lst_a[$];
        merge_req_t lst_b[$];
        merge_req_t r;
        build_list(LIST_A, la, lst_a);
        build_list(LIST_B, lb, lst_b);
        while (lst_a.size() > 0 || lst_b.size() > 0)
        begin
            if (lst_b.size() == 0 || (lst_a.size() > 0 && $urandom_range(0, 1) == 0))
                r = lst_a.pop_front();
            else
                r = lst_b.pop_front();
            pending_reqs.push_back(r);
            if ($urandom_range(0, 11) == 0)
                add_noise();
            if ((r.is_last || r.list_empty) && $urandom_range(0, 9) == 0)
                add_req(r.kind, $urandom, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
        end
    endtask

    task automatic build_overflow(logic k);
        fill_sorted(QUEUE_DEPTH + 1, $urandom_range(0, 3));
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            add_req(k, sort_buf[i], (i == QUEUE_DEPTH) ? 1'($urandom_range(0, 1)) : 1'b0,
                    1'b0);
        add_req(k, $urandom, 1'($urandom_range(0, 1)), 1'b1);
        fill_sorted($urandom_range(1, 3), $urandom_range(0, 3));
        for (int i = 0; i < sort_buf.size(); i++)
            add_req(!k, sort_buf[i], (i == sort_buf.size() - 1), 1'b0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_merge(cur_req);
                in_gap = pick_gap(in_calm);
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    kind       <= cur_req.kind;
                    value      <= cur_req.value;
                    is_last    <= cur_req.is_last;
                    list_empty <= cur_req.list_empty;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        merge_res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (merge_expected.size() == 0)
                begin
                    report_mismatch("unexpected result", out_value, '0);
                end
                else
                begin
                    want = merge_expected.pop_front();
                    if (out_value !== want.out_value)
                        report_mismatch("out_value", out_value, want.out_value);
                    if (source !== want.source)
                        report_mismatch("source", DATA_W'(source), DATA_W'(want.source));
                    if (status !== want.status)
                        report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
                    if (merge_end !== want.merge_end)
                        report_mismatch("merge_end", DATA_W'(merge_end),
                                        DATA_W'(want.merge_end));
                    if (run_last !== want.run_last)
                        report_mismatch("run_last", DATA_W'(run_last),
                                        DATA_W'(want.run_last));
                end
                out_gap = pick_gap(out_calm);
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int directed;
        int r;
        add_req(LIST_A, 32'hFFFFFFFF, 1'b1, 1'b1);
        add_req(LIST_B, 32'h00000000, 1'b0, 1'b1);
        add_req(LIST_A, 32'h80000000, 1'b1, 1'b0);
        add_req(LIST_B, 32'h7FFFFFFF, 1'b1, 1'b0);
        add_req(LIST_B, 32'h7FFFFFFF, 1'b0, 1'b0);
        add_req(LIST_B, 32'h7FFFFFFF, 1'b1, 1'b0);
        add_req(LIST_A, 32'h80000000, 1'b0, 1'b0);
        add_req(LIST_A, 32'h7FFFFFFF, 1'b1, 1'b0);
        add_req(LIST_A, 32'd7, 1'b0, 1'b0);
        add_req(LIST_B, 32'd7, 1'b0, 1'b0);
        add_req(LIST_A, 32'd7, 1'b1, 1'b0);
        add_req(LIST_B, 32'd7, 1'b1, 1'b0);
        add_req(LIST_A, 32'd3, 1'b1, 1'b0);
        add_req(LIST_A, 32'd4, 1'b0, 1'b0);
        add_req(LIST_A, 32'd5, 1'b1, 1'b1);
        add_req(LIST_B, 32'hFFFFFFFF, 1'b1, 1'b0);
        add_req(LIST_A, 32'd1, 1'b0, 1'b0);
        add_req(LIST_A, 32'd2, 1'b0, 1'b0);
        add_req(LIST_A, 32'd0, 1'b1, 1'b1);
        add_req(LIST_B, 32'd0, 1'b0, 1'b1);
        add_req(LIST_B, 32'd0, 1'b0, 1'b1);
        add_req(LIST_A, 32'd10, 1'b0, 1'b0);
        add_req(LIST_A, 32'd20, 1'b1, 1'b0);
        directed = pending_reqs.size();

        build_overflow(LIST_A);
        build_overflow(LIST_B);
        while (pending_reqs.size() - directed < RANDOM_REQS)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                build_overflow(1'($urandom_range(0, 1)));
            else if (r < 13)
                repeat ($urandom_range(1, 4)) add_noise();
            else
                build_merge(pick_len(), pick_len());
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || in_valid)
            @(negedge clk);
        while (merge_expected.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (merge_expected.size() > 0)
            report_mismatch("results never arrived", merge_expected.size(), 0);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
